FILE: design/stm_pkg.sv
// Package of the sliding truncated mean block: field widths, window limits,
// register indexes and reset values. Depends on nothing.
package stm_pkg;

  localparam int RING_AW         = 7;
  localparam int RING_DEPTH      = 1 << RING_AW;
  localparam int MAX_HALF_WINDOW = 63;
  localparam int HALF_CAP        = (RING_DEPTH - 1) / 2;
  localparam int HALF_LIMIT      = (MAX_HALF_WINDOW < HALF_CAP) ? MAX_HALF_WINDOW : HALF_CAP;

  localparam int RANGE_W  = 16;
  localparam int CHARGE_W = 24;
  localparam int RADIUS_W = 12;
  localparam int SIGMA_W  = 8;
  localparam int KEPT_W   = 7;
  localparam int HELD_W   = 8;
  localparam int HALF_W   = 6;

  // Accumulator and cut arithmetic widths.
  localparam int S1_W   = 31;
  localparam int S2_W   = 55;
  localparam int SQ_W   = 48;
  localparam int Q_W    = 62;
  localparam int SS_W   = 16;
  localparam int LF_W   = 22;
  localparam int LHS_W  = 70;
  localparam int WIDE_W = 80;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd48;
  localparam logic [SIGMA_W-1:0]  SIGMA_RESET  = 8'd16;
  localparam logic [SIGMA_W-1:0]  SIGMA_ONE    = 8'd16;
  localparam logic [HELD_W-1:0]   HELD_MAX     = 8'd255;

endpackage

FILE: design/stm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module stm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/sliding_truncated_mean.sv
// Sliding truncated mean over a track of points. Depends on stm_pkg and stm_ram.
//
// Each accepted point is written to a 128-entry ring. Once H = floor(6*radius/16)
// (at most 63) later points have arrived, or on the last point of the track,
// the block emits one result per pending point, in order. For each result it
// scans the index window through the ring RAM (up to 2H+1 entries), stores
// the k neighbors in a buffer RAM, finds the upper median bit by bit (24 passes
// over the buffer's single read port), runs a pipelined cut pass and a radix-2
// divider. Input is stalled while results are computed; the output register
// lets the next point enter while the last result waits. Configuration
// writes are always ready.
module sliding_truncated_mean (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [stm_pkg::RANGE_W-1:0]     in_residual_range,
  input  logic [stm_pkg::CHARGE_W-1:0]    in_charge,
  input  logic                            in_last_point,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stm_pkg::CHARGE_W-1:0]    out_truncated_charge,
  output logic                            out_used_fallback,
  output logic [stm_pkg::KEPT_W-1:0]      out_kept_count,
  output logic                            out_last_result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [stm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW  = stm_pkg::RING_AW;
  localparam int RW  = stm_pkg::RANGE_W;
  localparam int CW  = stm_pkg::CHARGE_W;
  localparam int KW  = stm_pkg::KEPT_W;
  localparam int HW  = stm_pkg::HALF_W;
  localparam int QW  = stm_pkg::Q_W;
  localparam int SSW = stm_pkg::SS_W;
  localparam int LFW = stm_pkg::LF_W;
  localparam int LW  = stm_pkg::LHS_W;
  localparam int WW  = stm_pkg::WIDE_W;
  localparam int S1W = stm_pkg::S1_W;
  localparam int S2W = stm_pkg::S2_W;
  localparam int SQW = stm_pkg::SQ_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_CENTER   = 4'd2;
  localparam logic [3:0] S_CENTER_D = 4'd3;
  localparam logic [3:0] S_COLLECT  = 4'd4;
  localparam logic [3:0] S_STAT1    = 4'd5;
  localparam logic [3:0] S_STAT2    = 4'd6;
  localparam logic [3:0] S_STAT3    = 4'd7;
  localparam logic [3:0] S_MED      = 4'd8;
  localparam logic [3:0] S_KEEP     = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_RESULT   = 4'd11;

  logic [3:0] state_r;

  logic [stm_pkg::RADIUS_W-1:0] radius_r;
  logic [stm_pkg::SIGMA_W-1:0]  sigma_r;
  logic                         mode_r;

  logic [AW-1:0]               write_slot_r;
  logic [AW-1:0]               next_emit_r;
  logic [stm_pkg::HELD_W-1:0]  held_r;
  logic                        last_r;

  logic [AW-1:0] start_r;
  logic [AW-1:0] total_r;
  logic [AW-1:0] j_r;
  logic          iss_r;

  logic [RW-1:0]  r0_r;
  logic [CW-1:0]  c0_r;
  logic [KW-1:0]  k_r;
  logic [S1W-1:0] s1_r;
  logic [S2W-1:0] s2_r;
  logic           sq_vld_r;
  logic [SQW-1:0] sq_r;

  logic [QW-1:0]  ks2_r;
  logic [QW-1:0]  s1sq_r;
  logic [QW-1:0]  q_r;
  logic [SSW-1:0] ss_r;
  logic [LFW-1:0] lf_r;
  logic [WW-1:0]  rhs_r;

  logic [CW-1:0] p_r;
  logic [KW-1:0] rank_r;
  logic [KW-1:0] cnt_r;
  logic [4:0]    b_r;

  logic           v1_r, v2_r, v3_r;
  logic [CW-1:0]  d1_r, x1_r, x2_r, x3_r;
  logic [SQW-1:0] d2_r;
  logic [LW-1:0]  lhs_r;
  logic [S1W-1:0] sum_r;
  logic [KW-1:0]  kept_r;

  logic [S1W-1:0] quo_r;
  logic [KW-1:0]  rem_r;
  logic [4:0]     dcnt_r;

  logic [CW-1:0] res_charge_r;
  logic          res_fb_r;
  logic [KW-1:0] res_kept_r;

  logic          out_valid_r;
  logic [CW-1:0] out_charge_r;
  logic          out_fb_r;
  logic [KW-1:0] out_kept_r;
  logic          out_last_r;

  // Window bookkeeping.
  logic [14:0]    radius_x6;
  logic [10:0]    half_raw;
  logic [HW-1:0]  half_w;
  logic [AW-1:0]  pending;
  logic           emit_go;
  logic [stm_pkg::HELD_W-1:0] before_raw;
  logic [HW-1:0]  before_c;
  logic [AW-1:0]  pend_m1;
  logic [HW-1:0]  after_c;

  logic [RW+CW-1:0] ring_rdata;
  logic [AW-1:0]    ring_raddr;
  logic             ring_we;
  logic [RW-1:0]    rd_range;
  logic [CW-1:0]    rd_charge;
  logic [RW-1:0]    dr;
  logic             in_win;

  logic          nb_we;
  logic [CW-1:0] nb_rdata;

  logic [AW-1:0] scan_lim;
  logic          scan_more;
  logic [CW-1:0] hi_mask;
  logic          med_match;
  logic          fb_now;

  logic [KW:0]    rem_sh;
  logic           div_ge;
  logic [S1W-1:0] quo_nxt;
  logic [KW:0]    rem_diff;
  logic [CW-1:0]  mean_sat;
  logic [KW-1:0]  cnt_pass;

  assign radius_x6 = 15'(radius_r) * 15'd6;
  assign half_raw  = radius_x6[14:4];
  assign half_w    = (half_raw > 11'(stm_pkg::HALF_LIMIT)) ? HW'(stm_pkg::HALF_LIMIT)
                                                           : half_raw[HW-1:0];
  assign pending   = write_slot_r - next_emit_r;
  assign emit_go   = (pending != '0) && (last_r || (pending > AW'(half_w)));

  assign before_raw = (held_r > 8'(pending)) ? (held_r - 8'(pending)) : '0;
  assign before_c   = (before_raw > 8'(half_w)) ? half_w : before_raw[HW-1:0];
  assign pend_m1    = pending - 7'd1;
  assign after_c    = (pend_m1 > AW'(half_w)) ? half_w : pend_m1[HW-1:0];

  assign ring_we    = (state_r == S_IDLE) && in_valid;
  assign ring_raddr = (state_r == S_CENTER) ? next_emit_r : (start_r + j_r);
  assign rd_range   = ring_rdata[RW+CW-1:CW];
  assign rd_charge  = ring_rdata[CW-1:0];
  assign dr         = (rd_range > r0_r) ? (rd_range - r0_r) : (r0_r - rd_range);
  assign in_win     = mode_r ? (dr <= RW'(radius_r)) : (dr < RW'(radius_r));
  assign nb_we      = (state_r == S_COLLECT) && iss_r && in_win;

  assign scan_lim  = (state_r == S_COLLECT) ? total_r : k_r;
  assign scan_more = (j_r != scan_lim);

  // Values that share the prefix above the current bit and have a zero there.
  assign hi_mask   = {CW{1'b1}} << (b_r + 5'd1);
  assign med_match = (((nb_rdata ^ p_r) & hi_mask) == '0) && !nb_rdata[b_r];
  assign cnt_pass  = cnt_r;

  assign fb_now = (k_r == '0) || (!mode_r && (k_r <= 7'd1));

  assign rem_sh   = {rem_r, quo_r[S1W-1]};
  assign div_ge   = rem_sh >= {1'b0, kept_r};
  assign rem_diff = rem_sh - {1'b0, kept_r};
  assign quo_nxt  = {quo_r[S1W-2:0], div_ge};
  assign mean_sat = (quo_nxt[S1W-1:CW] != '0) ? {CW{1'b1}} : quo_nxt[CW-1:0];

  stm_ram #(.WIDTH(RW + CW), .DEPTH(stm_pkg::RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot_r),
    .wdata ({in_residual_range, in_charge}),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  stm_ram #(.WIDTH(CW), .DEPTH(stm_pkg::RING_DEPTH)) u_nbuf (
    .clk   (clk),
    .we    (nb_we),
    .waddr (k_r),
    .wdata (rd_charge),
    .raddr (j_r),
    .rdata (nb_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      radius_r     <= stm_pkg::RADIUS_RESET;
      sigma_r      <= stm_pkg::SIGMA_RESET;
      mode_r       <= 1'b0;
      write_slot_r <= '0;
      next_emit_r  <= '0;
      held_r       <= '0;
      last_r       <= 1'b0;
      iss_r        <= 1'b0;
      sq_vld_r     <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          stm_pkg::CFG_RADIUS: radius_r <= cfg_data;
          stm_pkg::CFG_SIGMA:  sigma_r  <= cfg_data[stm_pkg::SIGMA_W-1:0];
          stm_pkg::CFG_MODE:   mode_r   <= cfg_data[0];
          default: ;
        endcase
      end

      if (!out_stall && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            write_slot_r <= write_slot_r + 7'd1;
            if (held_r != stm_pkg::HELD_MAX) begin
              held_r <= held_r + 8'd1;
            end
            last_r  <= in_last_point;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (emit_go) begin
            start_r <= next_emit_r - AW'(before_c);
            total_r <= AW'(before_c) + AW'(after_c) + 7'd1;
            state_r <= S_CENTER;
          end else begin
            if (last_r) begin
              held_r       <= '0;
              next_emit_r  <= '0;
              write_slot_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        S_CENTER: begin
          state_r <= S_CENTER_D;
        end
        S_CENTER_D: begin
          r0_r     <= rd_range;
          c0_r     <= rd_charge;
          k_r      <= '0;
          s1_r     <= '0;
          s2_r     <= '0;
          j_r      <= '0;
          iss_r    <= 1'b0;
          sq_vld_r <= 1'b0;
          state_r  <= S_COLLECT;
        end
        S_COLLECT: begin
          iss_r <= scan_more;
          if (scan_more) begin
            j_r <= j_r + 7'd1;
          end
          sq_vld_r <= iss_r && in_win;
          sq_r     <= SQW'(rd_charge) * SQW'(rd_charge);
          if (iss_r && in_win) begin
            k_r  <= k_r + 7'd1;
            s1_r <= s1_r + S1W'(rd_charge);
          end
          if (sq_vld_r) begin
            s2_r <= s2_r + S2W'(sq_r);
          end
          if (!scan_more && !iss_r && !sq_vld_r) begin
            if (fb_now) begin
              res_charge_r <= c0_r;
              res_fb_r     <= 1'b1;
              res_kept_r   <= '0;
              state_r      <= S_RESULT;
            end else begin
              state_r <= S_STAT1;
            end
          end
        end
        S_STAT1: begin
          ks2_r   <= QW'(k_r) * QW'(s2_r);
          s1sq_r  <= QW'(s1_r) * QW'(s1_r);
          ss_r    <= mode_r ? (SSW'(sigma_r) * SSW'(sigma_r))
                            : (SSW'(stm_pkg::SIGMA_ONE) * SSW'(stm_pkg::SIGMA_ONE));
          lf_r    <= {14'(k_r) * 14'(k_r - 7'd1), 8'd0};
          state_r <= S_STAT2;
        end
        S_STAT2: begin
          q_r     <= ks2_r - s1sq_r;
          state_r <= S_STAT3;
        end
        S_STAT3: begin
          rhs_r   <= WW'(q_r) * WW'(ss_r);
          p_r     <= '0;
          rank_r  <= k_r >> 1;
          b_r     <= 5'(CW - 1);
          cnt_r   <= '0;
          j_r     <= '0;
          iss_r   <= 1'b0;
          state_r <= S_MED;
        end
        S_MED: begin
          iss_r <= scan_more;
          if (scan_more) begin
            j_r <= j_r + 7'd1;
          end
          if (iss_r && med_match) begin
            cnt_r <= cnt_r + 7'd1;
          end
          if (!scan_more && !iss_r) begin
            // The rank falls among the values with a zero at this bit, or past them.
            if (rank_r >= cnt_pass) begin
              p_r[b_r] <= 1'b1;
              rank_r   <= rank_r - cnt_pass;
            end
            cnt_r <= '0;
            j_r   <= '0;
            if (b_r == 5'd0) begin
              sum_r   <= '0;
              kept_r  <= '0;
              v1_r    <= 1'b0;
              v2_r    <= 1'b0;
              v3_r    <= 1'b0;
              state_r <= S_KEEP;
            end else begin
              b_r <= b_r - 5'd1;
            end
          end
        end
        S_KEEP: begin
          iss_r <= scan_more;
          if (scan_more) begin
            j_r <= j_r + 7'd1;
          end
          v1_r  <= iss_r;
          x1_r  <= nb_rdata;
          d1_r  <= (nb_rdata > p_r) ? (nb_rdata - p_r) : (p_r - nb_rdata);
          v2_r  <= v1_r;
          x2_r  <= x1_r;
          d2_r  <= SQW'(d1_r) * SQW'(d1_r);
          v3_r  <= v2_r;
          x3_r  <= x2_r;
          lhs_r <= LW'(d2_r) * LW'(lf_r);
          if (v3_r && (WW'(lhs_r) < rhs_r)) begin
            sum_r  <= sum_r + S1W'(x3_r);
            kept_r <= kept_r + 7'd1;
          end
          if (!scan_more && !iss_r && !v1_r && !v2_r && !v3_r) begin
            if (kept_r == '0) begin
              res_charge_r <= c0_r;
              res_fb_r     <= 1'b1;
              res_kept_r   <= '0;
              state_r      <= S_RESULT;
            end else begin
              quo_r   <= sum_r;
              rem_r   <= '0;
              dcnt_r  <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo_r  <= quo_nxt;
          rem_r  <= div_ge ? rem_diff[KW-1:0] : rem_sh[KW-1:0];
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'(S1W - 1)) begin
            res_charge_r <= mean_sat;
            res_fb_r     <= 1'b0;
            res_kept_r   <= kept_r;
            state_r      <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_charge_r <= res_charge_r;
            out_fb_r     <= res_fb_r;
            out_kept_r   <= res_kept_r;
            out_last_r   <= last_r && (pending == 7'd1);
            next_emit_r  <= next_emit_r + 7'd1;
            state_r      <= S_CHECK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_truncated_charge = out_charge_r;
  assign out_used_fallback    = out_fb_r;
  assign out_kept_count       = out_kept_r;
  assign out_last_result      = out_last_r;

endmodule
